### sv/egbr_pkg.sv
// Shared types and codes for the Exp-Golomb bit reader.
// Used by egbr_step and exp_golomb_bit_reader; depends on nothing.
package egbr_pkg;

  localparam logic [2:0] CMD_PUSH     = 3'd0;
  localparam logic [2:0] CMD_UNSIGNED = 3'd1;
  localparam logic [2:0] CMD_SIGNMAG  = 3'd2;
  localparam logic [2:0] CMD_UE       = 3'd3;
  localparam logic [2:0] CMD_SE       = 3'd4;
  localparam logic [2:0] CMD_SKIP     = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NODATA = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_WIDTH  = 3'd3;
  localparam logic [2:0] ST_LONG   = 3'd4;

  localparam int MAX_FIELD = 32;
  localparam int MAX_SKIP  = 64;
  localparam int MAX_ZEROS = 32;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] stream_byte;
    logic [6:0] bit_count;
  } in_word_t;

  typedef struct packed {
    logic signed [32:0] value;
    logic [2:0]         status;
    logic [2:0]         bits_to_align;
    logic [31:0]        bytes_consumed;
    logic [6:0]         bits_held;
  } out_word_t;

endpackage

### sv/exp_golomb_bit_reader.sv
// Top level of the Exp-Golomb bit reader: input word register, step logic, result register.
// Depends on egbr_pkg and egbr_step.

// Exp-Golomb bit reader. Each command word either pushes one stream byte into an
// MSB-first window of WINDOW_BITS bits or reads one syntax element from its head
// (unsigned field, sign-magnitude field, ue(v), se(v) or skip) and returns exactly
// one result word. A word is held in the input register and decoded there by a
// single pass through a 32-bit leading-zero count and the window shifters, and its
// result goes to the output register once that is empty or unstalled; one word per
// cycle is sustained while the result side does not stall. The command channel
// stalls only while both registers are full and the result side stalls. Errors
// consume nothing and return value zero.
module exp_golomb_bit_reader #(
  parameter int WINDOW_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  egbr_pkg::in_word_t  cmd_word,
  output logic                res_valid,
  input  logic                res_stall,
  output egbr_pkg::out_word_t res_word
);

  localparam int FILL_W = $clog2(WINDOW_BITS + 1);

  logic                   item_valid;
  egbr_pkg::in_word_t     item;
  logic                   result_valid;
  egbr_pkg::out_word_t    result;
  logic [WINDOW_BITS-1:0] window;
  logic [FILL_W-1:0]      fill;
  logic [31:0]            taken;

  logic [WINDOW_BITS-1:0] window_next;
  logic [FILL_W-1:0]      fill_next;
  logic [31:0]            taken_next;
  egbr_pkg::out_word_t    step_result;
  logic                   advance;

  egbr_step #(
    .WINDOW_BITS (WINDOW_BITS),
    .FILL_W      (FILL_W)
  ) u_step (
    .item        (item),
    .window      (window),
    .fill        (fill),
    .taken       (taken),
    .window_next (window_next),
    .fill_next   (fill_next),
    .taken_next  (taken_next),
    .result      (step_result)
  );

  assign advance   = !result_valid || !res_stall;
  assign cmd_stall = item_valid && !advance;
  assign res_valid = result_valid;
  assign res_word  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
      window       <= '0;
      fill         <= '0;
      taken        <= '0;
    end else begin
      if (advance) begin
        result_valid <= item_valid;
        if (item_valid) begin
          window <= window_next;
          fill   <= fill_next;
          taken  <= taken_next;
        end
      end
      if (!cmd_stall) begin
        item_valid <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result <= step_result;
    end
    if (!cmd_stall) begin
      item <= cmd_word;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (FILL_W+1)'(fill) <= (FILL_W+1)'(WINDOW_BITS))
    else $error("window fill exceeds window size");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != egbr_pkg::ST_OK |-> result.value == 33'sd0)
    else $error("error result carries a nonzero value");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    advance && item_valid && step_result.status != egbr_pkg::ST_OK
      |=> $stable(fill) && $stable(taken))
    else $error("failed command changed the window");

  a_taken_push_only: assert property (@(posedge clk) disable iff (rst)
    advance && item_valid && item.command != egbr_pkg::CMD_PUSH |=> $stable(taken))
    else $error("byte count moved on a read");

endmodule

### sv/egbr_lzc.sv
// Leading-zero counter over the first 32 bits of the window.
// Depends on nothing; used by egbr_step.
module egbr_lzc (
  input  logic [31:0] bits,
  output logic [5:0]  count
);

  // Lowest index first so the highest set bit wins; all zero gives 32.
  always_comb begin
    count = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (bits[i]) begin
        count = 6'(31 - i);
      end
    end
  end

endmodule

### sv/egbr_step.sv
// One command applied to the bit window: push, field read, ue/se decode, skip.
// Depends on egbr_pkg and egbr_lzc; used by exp_golomb_bit_reader.
module egbr_step #(
  parameter int WINDOW_BITS = 64,
  parameter int FILL_W      = 7
) (
  input  egbr_pkg::in_word_t   item,
  input  logic [WINDOW_BITS-1:0] window,
  input  logic [FILL_W-1:0]    fill,
  input  logic [31:0]          taken,
  output logic [WINDOW_BITS-1:0] window_next,
  output logic [FILL_W-1:0]    fill_next,
  output logic [31:0]          taken_next,
  output egbr_pkg::out_word_t  result
);

  logic [63:0]            head;
  logic [5:0]             lz;
  logic [WINDOW_BITS-1:0] byte_vec;
  logic [FILL_W-1:0]      n_ext;
  logic [FILL_W-1:0]      code_len;
  logic [6:0]             drop;
  logic                   push_ok;
  logic [63:0]            raw;
  logic [63:0]            mag;
  logic [63:0]            code;
  logic [32:0]            code_mag;
  logic signed [32:0]     value;
  logic [2:0]             status;

  assign head = window[WINDOW_BITS-1 -: 64];

  egbr_lzc u_lzc (
    .bits  (head[63:32]),
    .count (lz)
  );

  assign byte_vec = {item.stream_byte, {(WINDOW_BITS-8){1'b0}}} >> fill;
  assign n_ext    = FILL_W'(item.bit_count);
  assign code_len = FILL_W'({lz[4:0], 1'b1});

  // Fields start at the window head: first bit is the sign for sign-magnitude.
  assign raw  = head >> (7'd64 - item.bit_count);
  assign mag  = {head[62:0], 1'b0} >> (8'd65 - {1'b0, item.bit_count});
  // Code word of 2z+1 bits equals codeNum + 1.
  assign code = head >> (7'd64 - 7'({lz[4:0], 1'b1}));
  assign code_mag = {1'b0, code[32:1]};

  always_comb begin
    value   = '0;
    status  = egbr_pkg::ST_OK;
    drop    = '0;
    push_ok = 1'b0;
    unique case (item.command) inside
      egbr_pkg::CMD_PUSH: begin
        if ((FILL_W+1)'(fill) + (FILL_W+1)'(8) > (FILL_W+1)'(WINDOW_BITS)) begin
          status = egbr_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      egbr_pkg::CMD_UNSIGNED, egbr_pkg::CMD_SIGNMAG: begin
        if (item.bit_count > 7'(egbr_pkg::MAX_FIELD)) begin
          status = egbr_pkg::ST_WIDTH;
        end else if (n_ext > fill) begin
          status = egbr_pkg::ST_NODATA;
        end else if (item.bit_count != 7'd0) begin
          drop = item.bit_count;
          if (item.command == egbr_pkg::CMD_UNSIGNED) begin
            value = 33'(raw[31:0]);
          end else if (head[63]) begin
            value = -33'(mag[31:0]);
          end else begin
            value = 33'(mag[31:0]);
          end
        end
      end
      egbr_pkg::CMD_UE, egbr_pkg::CMD_SE: begin
        if (lz[5] && fill >= FILL_W'(egbr_pkg::MAX_ZEROS)) begin
          status = egbr_pkg::ST_LONG;
        end else if (FILL_W'(lz) >= fill || code_len > fill) begin
          status = egbr_pkg::ST_NODATA;
        end else begin
          drop = 7'({lz[4:0], 1'b1});
          if (item.command == egbr_pkg::CMD_UE) begin
            value = code[32:0] - 33'd1;
          end else if (code[0]) begin
            // codeNum even: negative half
            value = -code_mag;
          end else begin
            value = code_mag;
          end
        end
      end
      egbr_pkg::CMD_SKIP: begin
        if (item.bit_count > 7'(egbr_pkg::MAX_SKIP)) begin
          status = egbr_pkg::ST_WIDTH;
        end else if (n_ext > fill) begin
          status = egbr_pkg::ST_NODATA;
        end else begin
          drop = item.bit_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (push_ok) begin
      window_next = window | byte_vec;
      fill_next   = fill + FILL_W'(8);
      taken_next  = taken + 32'd1;
    end else begin
      // Zeros shift in behind the held bits, so later pushes can OR in place.
      window_next = window << drop;
      fill_next   = fill - FILL_W'(drop);
      taken_next  = taken;
    end
  end

  always_comb begin
    result.value          = value;
    result.status         = status;
    result.bits_to_align  = fill_next[2:0];
    result.bits_held      = 7'(fill_next);
    result.bytes_consumed = taken_next - 32'((FILL_W+1)'(fill_next) + (FILL_W+1)'(7) >> 3);
  end

endmodule

### tb/sv/tb_exp_golomb_bit_reader.sv
`timescale 1ns / 1ps
// Self-checking testbench for exp_golomb_bit_reader: directed and random command words
// against an in-bench bit window predictor. Depends on egbr_pkg and the reader RTL.
module tb_exp_golomb_bit_reader;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         WINDOW     = 64;
  localparam int         MAX_CYCLES = 200000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  egbr_pkg::in_word_t  cmd_word = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  egbr_pkg::out_word_t res_word;

  // Predictor state
  logic [63:0] stream_window = '0;
  int unsigned held_bits = 0;
  logic [31:0] bytes_pushed = '0;

  egbr_pkg::out_word_t pending_results[$];
  int        errors = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  int        status_seen[5] = '{default: 0};
  int        cycles = 0;

  // Receiver and sender idling controls
  bit        quiet = 1'b0;
  int        hold_left = 0;
  int        stall_left = 0;

  logic [7:0] cmd_fill_bytes[8] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h00, 8'hFF};

  exp_golomb_bit_reader i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("exp_golomb_bit_reader: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] take_head(int unsigned n);
    logic [63:0] head;
    head = (n == 0) ? 64'd0 : stream_window >> (64 - n);
    stream_window = stream_window << n;
    held_bits = held_bits - n;
    return head;
  endfunction

  // Apply one command word to the predicted window and return the result word.
  function automatic egbr_pkg::out_word_t predict_element(egbr_pkg::in_word_t w);
    egbr_pkg::out_word_t r;
    logic [63:0] field;
    logic [63:0] mag;
    logic [32:0] val;
    logic [2:0]  st;
    int unsigned n;
    int unsigned zeros;
    val = '0;
    st = egbr_pkg::ST_OK;
    n = w.bit_count;
    case (w.command)
      egbr_pkg::CMD_PUSH: begin
        if (held_bits + 8 > WINDOW) begin
          st = egbr_pkg::ST_FULL;
        end else begin
          stream_window[63 - held_bits -: 8] = w.stream_byte;
          held_bits = held_bits + 8;
          bytes_pushed = bytes_pushed + 32'd1;
        end
      end
      egbr_pkg::CMD_UNSIGNED, egbr_pkg::CMD_SIGNMAG: begin
        if (n > egbr_pkg::MAX_FIELD) begin
          st = egbr_pkg::ST_WIDTH;
        end else if (n > held_bits) begin
          st = egbr_pkg::ST_NODATA;
        end else if (n > 0) begin
          field = take_head(n);
          if (w.command == egbr_pkg::CMD_UNSIGNED) begin
            val = field[32:0];
          end else begin
            // top bit is the sign, the rest is the magnitude
            mag = field & ((64'd1 << (n - 1)) - 64'd1);
            val = field[n - 1] ? 33'd0 - mag[32:0] : mag[32:0];
          end
        end
      end
      egbr_pkg::CMD_UE, egbr_pkg::CMD_SE: begin
        zeros = 0;
        while (zeros < held_bits && zeros < egbr_pkg::MAX_ZEROS && !stream_window[63 - zeros])
          zeros++;
        if (zeros >= egbr_pkg::MAX_ZEROS) begin
          st = egbr_pkg::ST_LONG;
        end else if (2 * zeros + 1 > held_bits) begin
          st = egbr_pkg::ST_NODATA;
        end else begin
          void'(take_head(zeros + 1));
          field = ((64'd1 << zeros) - 64'd1) + take_head(zeros);
          if (w.command == egbr_pkg::CMD_UE) begin
            val = field[32:0];
          end else begin
            mag = (field + 64'd1) >> 1;
            val = field[0] ? mag[32:0] : 33'd0 - mag[32:0];
          end
        end
      end
      egbr_pkg::CMD_SKIP: begin
        if (n > egbr_pkg::MAX_SKIP)
          st = egbr_pkg::ST_WIDTH;
        else if (n > held_bits)
          st = egbr_pkg::ST_NODATA;
        else
          void'(take_head(n));
      end
      default: ;
    endcase
    r.value = val;
    r.status = st;
    r.bits_to_align = held_bits[2:0];
    r.bytes_consumed = bytes_pushed - 32'((held_bits + 7) >> 3);
    r.bits_held = held_bits[6:0];
    return r;
  endfunction

  // Offer one word; return at the edge that accepts it, with valid still high.
  task automatic send_word(logic [2:0] cmd, logic [7:0] data, logic [6:0] count);
    egbr_pkg::in_word_t w;
    w.command = cmd;
    w.stream_byte = data;
    w.bit_count = count;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_results.push_back(predict_element(w));
    words_sent++;
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  function automatic egbr_pkg::in_word_t random_word();
    egbr_pkg::in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.stream_byte = 8'($urandom_range(0, 255));
    w.bit_count = 7'($urandom_range(0, 127));
    if (pick < 40) begin
      w.command = egbr_pkg::CMD_PUSH;
      // zero bytes now and then build long prefixes
      if ($urandom_range(0, 5) == 0)
        w.stream_byte = 8'h00;
    end else if (pick < 65) begin
      w.command = (pick < 55) ? egbr_pkg::CMD_UNSIGNED : egbr_pkg::CMD_SIGNMAG;
      if ($urandom_range(0, 19) != 0)
        w.bit_count = 7'($urandom_range(0, egbr_pkg::MAX_FIELD));
    end else if (pick < 88) begin
      w.command = (pick < 78) ? egbr_pkg::CMD_UE : egbr_pkg::CMD_SE;
    end else if (pick < 96) begin
      w.command = egbr_pkg::CMD_SKIP;
      if ($urandom_range(0, 9) != 0)
        w.bit_count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, egbr_pkg::MAX_SKIP))
                                                  : 7'($urandom_range(0, 12));
    end else begin
      w.command = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    end
    return w;
  endfunction

  task automatic test_limits_and_errors();
    send_word(egbr_pkg::CMD_UE, 8'h00, 7'd0);       // empty window
    send_word(egbr_pkg::CMD_UNSIGNED, 8'hFF, 7'd0); // zero width
    send_word(egbr_pkg::CMD_SKIP, 8'h00, 7'd0);
    foreach (cmd_fill_bytes[i])
      send_word(egbr_pkg::CMD_PUSH, cmd_fill_bytes[i], 7'd127);
    send_word(egbr_pkg::CMD_PUSH, 8'h12, 7'd0);     // window full
    send_word(egbr_pkg::CMD_UNSIGNED, 8'h00, 7'd33);
    send_word(egbr_pkg::CMD_SIGNMAG, 8'h00, 7'd127);
    send_word(egbr_pkg::CMD_SKIP, 8'h00, 7'd65);
    send_word(egbr_pkg::CMD_SIGNMAG, 8'h00, 7'd1);  // lone sign bit
    send_word(egbr_pkg::CMD_SIGNMAG, 8'h00, 7'd8);
    send_word(egbr_pkg::CMD_UNSIGNED, 8'h00, 7'd32);
    send_word(CMD_SPARE6, 8'hFF, 7'd64);
    send_word(CMD_SPARE7, 8'h00, 7'd1);
    send_word(egbr_pkg::CMD_SKIP, 8'h00, 7'd30);    // short
    send_word(egbr_pkg::CMD_SKIP, 8'h00, 7'd23);
    wait_for_results();
  endtask

  task automatic test_exp_golomb_codes();
    repeat (4) send_word(egbr_pkg::CMD_PUSH, 8'h00, 7'd0);
    send_word(egbr_pkg::CMD_PUSH, 8'h80, 7'd0);
    send_word(egbr_pkg::CMD_UE, 8'h00, 7'd0);       // 32 zeros: code too long
    send_word(egbr_pkg::CMD_SKIP, 8'h00, 7'd1);
    send_word(egbr_pkg::CMD_SE, 8'h00, 7'd0);       // 31 zeros, tail missing
    repeat (3) send_word(egbr_pkg::CMD_PUSH, 8'hFF, 7'd0);
    send_word(egbr_pkg::CMD_UE, 8'h00, 7'd0);       // longest legal code
    send_word(egbr_pkg::CMD_PUSH, 8'h4C, 7'd0);
    send_word(egbr_pkg::CMD_SE, 8'h00, 7'd0);
    send_word(egbr_pkg::CMD_SE, 8'h00, 7'd0);
    send_word(egbr_pkg::CMD_UE, 8'h00, 7'd0);
    send_word(egbr_pkg::CMD_UE, 8'h00, 7'd0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count);
    egbr_pkg::in_word_t w;
    repeat (count) begin
      w = random_word();
      send_word(w.command, w.stream_byte, w.bit_count);
    end
  endtask

  // Hold the result side long enough that the block backs up into its input.
  task automatic test_output_backpressure();
    egbr_pkg::in_word_t w;
    hold_left = 40;
    repeat (20) begin
      w = random_word();
      send_word(w.command, w.stream_byte, w.bit_count);
    end
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (quiet) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      res_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    egbr_pkg::out_word_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (res_word.status <= egbr_pkg::ST_LONG)
        status_seen[res_word.status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: value %0d status %0d",
               res_word.value, res_word.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_word.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, res_word.value);
          errors++;
        end
        if (res_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_word.status);
          errors++;
        end
        if (res_word.bits_to_align !== want.bits_to_align) begin
          $error("bits_to_align: expected %0d, got %0d",
                 want.bits_to_align, res_word.bits_to_align);
          errors++;
        end
        if (res_word.bytes_consumed !== want.bytes_consumed) begin
          $error("bytes_consumed: expected %0d, got %0d",
                 want.bytes_consumed, res_word.bytes_consumed);
          errors++;
        end
        if (res_word.bits_held !== want.bits_held) begin
          $error("bits_held: expected %0d, got %0d", want.bits_held, res_word.bits_held);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_limits_and_errors();
    test_exp_golomb_codes();
    test_random_traffic(300);
    test_output_backpressure();
    quiet = 1'b1;
    test_random_traffic(150);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() > 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Sent %0d command words and checked %0d results.", words_sent, results_seen);
    $display("Status counts ok/nodata/full/width/long: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0)
      $display("exp_golomb_bit_reader: match");
    else
      $display("exp_golomb_bit_reader: mismatch");
    $finish;
  end

endmodule
